/* rtl/core/rcs_pkg.sv */
// Shared constants for the reference clock selector.
`default_nettype none
package rcs_pkg;

	localparam int NUM_PORTS  = 8;
	localparam int NUM_CLOCKS = 8;
	localparam int PORT_W     = $clog2(NUM_PORTS);
	localparam int CLK_W      = 3;
	localparam int ST_W       = 4;

	// commands
	localparam logic [1:0] CMD_PORT_UPD = 2'd0;
	localparam logic [1:0] CMD_RECONFIG = 2'd1;
	localparam logic [1:0] CMD_INIT     = 2'd2;
	localparam logic [1:0] CMD_UNUSED   = 2'd3;

	// port and clock states
	localparam logic [ST_W-1:0] ST_NONE     = 4'd0;
	localparam logic [ST_W-1:0] ST_FAULTY   = 4'd2;
	localparam logic [ST_W-1:0] ST_DISABLED = 4'd3;
	localparam logic [ST_W-1:0] ST_PASSIVE  = 4'd7;
	localparam logic [ST_W-1:0] ST_UNCAL    = 4'd8;
	localparam logic [ST_W-1:0] ST_SLAVE    = 4'd9;

	// outcomes
	localparam logic [2:0] OUT_REF_SELECTED  = 3'd0;
	localparam logic [2:0] OUT_DEFAULT_REF   = 3'd1;
	localparam logic [2:0] OUT_MULTIPLE_REFS = 3'd2;
	localparam logic [2:0] OUT_REF_NOT_READY = 3'd3;
	localparam logic [2:0] OUT_NONE_READY    = 3'd4;
	localparam logic [2:0] OUT_NOTHING_SYNC  = 3'd5;
	localparam logic [2:0] OUT_NO_ACTION     = 3'd6;
	localparam logic [2:0] OUT_UNKNOWN_PORT  = 3'd7;

	// configuration register indexes
	localparam logic REG_PORT_CLOCK_MAP    = 1'b0;
	localparam logic REG_PORT_PRESENT_MASK = 1'b1;

endpackage
`default_nettype wire

/* rtl/core/reference_clock_selector_top.sv */
// Reference clock selector: port state table, clock state walk and reference pick.
//
//   channel | signals                                      | transfer when
//   --------+----------------------------------------------+------------------------
//   input   | in_valid in_ready command port_number        | in_valid && in_ready
//           | reported_state                               |
//   result  | out_valid out_ready outcome reference_valid  | out_valid && out_ready
//           | reference_clock target_mask change_pending   |
//   config  | cfg_we cfg_index cfg_data                    | cfg_we
//
// One item at a time. Port update: check, walk all ports, update the clock (an unknown
// or unchanged port stops after the check). Initialize: port walk, clock write walk.
// Reconfigure: clock walk, then pick (no walk if no change pends). Other: no walk.
// in_ready stays low while busy or while a result waits.
// Reset restores the state table at once; no clearing pass.
`default_nettype none
module reference_clock_selector_top
	import rcs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [23:0]      cfg_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       command,
	input  wire logic [3:0]       port_number,
	input  wire logic [ST_W-1:0]  reported_state,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [2:0]            outcome,
	output logic                  reference_valid,
	output logic [CLK_W-1:0]      reference_clock,
	output logic [7:0]            target_mask,
	output logic                  change_pending
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_PWALK = 3'd2;
	localparam logic [2:0] S_UPD   = 3'd3;
	localparam logic [2:0] S_IWR   = 3'd4;
	localparam logic [2:0] S_RWALK = 3'd5;
	localparam logic [2:0] S_RFIN  = 3'd6;

	logic [2:0]            state_q;
	logic [23:0]           map_q;
	logic [7:0]            present_q;
	logic [ST_W-1:0]       ps_q   [NUM_PORTS];
	logic [ST_W-1:0]       cs_q   [NUM_CLOCKS];
	logic [ST_W-1:0]       pend_q [NUM_CLOCKS];
	logic [ST_W-1:0]       acc_q  [NUM_CLOCKS];
	logic [NUM_CLOCKS-1:0] tgt_q;
	logic [CLK_W-1:0]      ref_idx_q;
	logic                  ref_present_q;
	logic                  change_q;
	logic                  out_valid_q;
	logic [2:0]            outcome_q;

	logic [1:0]            cmd_q;
	logic [3:0]            pnum_q;
	logic [ST_W-1:0]       pst_q;
	logic [PORT_W-1:0]     pw_q;
	logic [CLK_W-1:0]      cidx_q;
	logic [1:0]            nref_q;
	logic                  any_tgt_q;
	logic                  have_ref_q;
	logic [CLK_W-1:0]      sel_q;
	logic [CLK_W-1:0]      last_q;

	logic [CLK_W-1:0]      port_clk [NUM_PORTS];
	logic [NUM_PORTS-1:0]  port_ex;
	logic [NUM_CLOCKS-1:0] clk_ex;

	always_comb begin
		for (int p = 0; p < NUM_PORTS; p++) begin
			port_clk[p] = map_q[CLK_W*p +: CLK_W];
			port_ex[p]  = present_q[p] && ({1'b0, port_clk[p]} < (CLK_W+1)'(NUM_CLOCKS));
		end
		for (int c = 0; c < NUM_CLOCKS; c++) begin
			clk_ex[c] = 1'b0;
			for (int p = 0; p < NUM_PORTS; p++)
				if (port_ex[p] && port_clk[p] == CLK_W'(c))
					clk_ex[c] = 1'b1;
		end
	end

	// single read points into the port and clock tables
	logic [ST_W-1:0]  ps_rd;
	logic [CLK_W-1:0] pw_clk;
	logic [CLK_W-1:0] acc_addr;
	logic [ST_W-1:0]  acc_rd;
	logic [CLK_W-1:0] cl_addr;
	logic [ST_W-1:0]  cs_rd;
	logic [ST_W-1:0]  pend_rd;
	logic             cl_ex_rd;
	logic [ST_W-1:0]  s_eff;
	logic             pnum_ok;
	logic             pw_last;
	logic             cidx_last;

	assign ps_rd     = ps_q[pw_q];
	assign pw_clk    = port_clk[pw_q];
	assign acc_addr  = (state_q == S_PWALK) ? pw_clk : cidx_q;
	assign acc_rd    = acc_q[acc_addr];
	assign cl_addr   = (state_q == S_RFIN) ? last_q : cidx_q;
	assign cs_rd     = cs_q[cl_addr];
	assign pend_rd   = pend_q[cl_addr];
	assign cl_ex_rd  = clk_ex[cl_addr];
	assign s_eff     = (pend_rd != ST_NONE) ? pend_rd : cs_rd;
	assign pnum_ok   = (pnum_q != 4'd0) && (pnum_q <= 4'(NUM_PORTS)) && port_ex[pw_q];
	assign pw_last   = (pw_q == PORT_W'(NUM_PORTS - 1));
	assign cidx_last = (cidx_q == CLK_W'(NUM_CLOCKS - 1));

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;

	// shared max unit: accumulate the largest port state per clock
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			for (int c = 0; c < NUM_CLOCKS; c++)
				acc_q[c] <= ST_DISABLED;
		end else if (state_q == S_PWALK) begin
			if (port_ex[pw_q] && ps_rd > acc_rd)
				acc_q[acc_addr] <= ps_rd;
		end else if (state_q == S_IDLE && in_valid && in_ready && command == CMD_INIT) begin
			for (int c = 0; c < NUM_CLOCKS; c++)
				acc_q[c] <= ST_DISABLED;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_ready) begin
			cmd_q  <= command;
			pnum_q <= port_number;
			pst_q  <= reported_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			map_q         <= '0;
			present_q     <= '0;
			for (int p = 0; p < NUM_PORTS; p++)
				ps_q[p] <= ST_DISABLED;
			for (int c = 0; c < NUM_CLOCKS; c++) begin
				cs_q[c]   <= ST_NONE;
				pend_q[c] <= ST_NONE;
			end
			tgt_q         <= '0;
			ref_idx_q     <= '0;
			ref_present_q <= 1'b0;
			change_q      <= 1'b0;
			out_valid_q   <= 1'b0;
			outcome_q     <= OUT_NO_ACTION;
			pw_q          <= '0;
			cidx_q        <= '0;
			nref_q        <= '0;
			any_tgt_q     <= 1'b0;
			have_ref_q    <= 1'b0;
			sel_q         <= '0;
			last_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PORT_CLOCK_MAP:    map_q     <= cfg_data;
					REG_PORT_PRESENT_MASK: present_q <= cfg_data[7:0];
					default: ;
				endcase
			end

			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cidx_q <= '0;
						unique case (command)
							CMD_PORT_UPD: begin
								pw_q    <= PORT_W'(port_number - 4'd1);
								state_q <= S_CHECK;
							end
							CMD_INIT: begin
								pw_q    <= '0;
								state_q <= S_PWALK;
							end
							CMD_RECONFIG: begin
								if (change_q) begin
									change_q   <= 1'b0;
									nref_q     <= '0;
									any_tgt_q  <= 1'b0;
									have_ref_q <= 1'b0;
									sel_q      <= '0;
									last_q     <= '0;
									state_q    <= S_RWALK;
								end else begin
									outcome_q   <= OUT_NO_ACTION;
									out_valid_q <= 1'b1;
								end
							end
							CMD_UNUSED: begin
								outcome_q   <= OUT_NO_ACTION;
								out_valid_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				S_CHECK: begin
					if (!pnum_ok) begin
						outcome_q   <= OUT_UNKNOWN_PORT;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (ps_rd == pst_q) begin
						outcome_q   <= OUT_NO_ACTION;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						ps_q[pw_q] <= pst_q;
						cidx_q     <= pw_clk;
						pw_q       <= '0;
						state_q    <= S_PWALK;
					end
				end
				S_PWALK: begin
					pw_q <= pw_q + PORT_W'(1);
					if (pw_last)
						state_q <= (cmd_q == CMD_PORT_UPD) ? S_UPD : S_IWR;
				end
				S_UPD: begin
					if (cs_rd != acc_rd || pend_rd != ST_NONE) begin
						pend_q[cidx_q] <= acc_rd;
						change_q       <= 1'b1;
					end
					outcome_q   <= OUT_NO_ACTION;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_IWR: begin
					if (cl_ex_rd)
						pend_q[cidx_q] <= acc_rd;
					cidx_q <= cidx_q + CLK_W'(1);
					if (cidx_last) begin
						change_q    <= 1'b1;
						outcome_q   <= OUT_NO_ACTION;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_RWALK: begin
					// commit the pending state and classify one clock per cycle
					if (cl_ex_rd) begin
						if (pend_rd != ST_NONE) begin
							cs_q[cidx_q]   <= pend_rd;
							pend_q[cidx_q] <= ST_NONE;
						end
						if (s_eff >= ST_FAULTY && s_eff <= ST_PASSIVE) begin
							tgt_q[cidx_q] <= 1'b1;
							any_tgt_q     <= 1'b1;
						end else if (s_eff == ST_UNCAL) begin
							if (nref_q != 2'd2)
								nref_q <= nref_q + 2'd1;
						end else if (s_eff == ST_SLAVE) begin
							sel_q      <= cidx_q;
							have_ref_q <= 1'b1;
							if (nref_q != 2'd2)
								nref_q <= nref_q + 2'd1;
						end
						last_q <= cidx_q;
					end
					cidx_q <= cidx_q + CLK_W'(1);
					if (cidx_last)
						state_q <= S_RFIN;
				end
				S_RFIN: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
					priority if (any_tgt_q && !have_ref_q) begin
						// fall back to the highest existing clock
						ref_idx_q      <= last_q;
						ref_present_q  <= 1'b1;
						tgt_q[last_q]  <= 1'b0;
						pend_q[last_q] <= cs_rd;
						cs_q[last_q]   <= ST_SLAVE;
						outcome_q      <= OUT_DEFAULT_REF;
					end else if (nref_q == 2'd2) begin
						ref_present_q <= 1'b0;
						ref_idx_q     <= '0;
						outcome_q     <= OUT_MULTIPLE_REFS;
					end else if (nref_q != 2'd0 && !have_ref_q) begin
						ref_present_q <= 1'b0;
						ref_idx_q     <= '0;
						outcome_q     <= OUT_REF_NOT_READY;
					end else if (nref_q == 2'd0 && !any_tgt_q) begin
						ref_present_q <= 1'b0;
						ref_idx_q     <= '0;
						outcome_q     <= OUT_NONE_READY;
					end else if (nref_q == 2'd0) begin
						ref_present_q <= 1'b0;
						ref_idx_q     <= '0;
						outcome_q     <= OUT_NOTHING_SYNC;
					end else begin
						tgt_q[sel_q]  <= 1'b0;
						ref_idx_q     <= sel_q;
						ref_present_q <= 1'b1;
						outcome_q     <= OUT_REF_SELECTED;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign outcome         = outcome_q;
	assign reference_valid = ref_present_q;
	assign reference_clock = ref_present_q ? ref_idx_q : '0;
	assign target_mask     = 8'(tgt_q);
	assign change_pending  = change_q;

endmodule
`default_nettype wire

/* rtl/core/rcs_checker.sv */
// Port-level checks for the reference clock selector, bound to the top level.
`default_nettype none
module rcs_checker
	import rcs_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [2:0]       outcome,
	input wire logic             reference_valid,
	input wire logic [CLK_W-1:0] reference_clock,
	input wire logic             change_pending
);

	// a transfer in leaves the block busy in the next cycle
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken in back-to-back cycles");

	// no new item while a result waits
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a result waits");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(outcome))
		else $error("stalled result changed");

	a_ref_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!reference_valid |-> reference_clock == '0)
		else $error("reference clock nonzero without a reference");

	// a chosen reference comes with the change flag cleared
	a_ref_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == OUT_REF_SELECTED || outcome == OUT_DEFAULT_REF)
		|-> reference_valid && !change_pending)
		else $error("reference outcome without reference or with change pending");

endmodule

bind reference_clock_selector_top rcs_checker u_rcs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.outcome         (outcome),
	.reference_valid (reference_valid),
	.reference_clock (reference_clock),
	.change_pending  (change_pending)
);
`default_nettype wire

/* tb/tb_reference_clock_selector_top.sv */
// Self-checking testbench for the reference clock selector top level.
`timescale 1ns / 1ps
module tb_reference_clock_selector_top;
	import rcs_pkg::*;

	localparam int LONG_HOLD  = 300;
	localparam int QUIET_MAX  = 3000;
	localparam int TAIL_WAIT  = 20;

	typedef struct packed {
		logic [1:0]      cmd;
		logic [3:0]      pnum;
		logic [ST_W-1:0] pst;
	} sel_cmd_t;

	typedef struct packed {
		logic [2:0]       outcome;
		logic             ref_valid;
		logic [CLK_W-1:0] ref_clk;
		logic [7:0]       tmask;
		logic             pend;
	} sel_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_index = REG_PORT_CLOCK_MAP;
	logic [23:0]      cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       command = CMD_UNUSED;
	logic [3:0]       port_number = '0;
	logic [ST_W-1:0]  reported_state = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [2:0]       outcome;
	logic             reference_valid;
	logic [CLK_W-1:0] reference_clock;
	logic [7:0]       target_mask;
	logic             change_pending;

	// stimulus and scoreboard bookkeeping
	sel_cmd_t    command_q[$];
	sel_result_t selection_q[$];
	int          cmds_queued = 0;
	int          cmds_offered = 0;
	int          in_xfers = 0;
	int          err_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          stall_long = 1'b0;
	bit          hold_done = 1'b0;
	int          hold_left = 0;
	int          quiet_cycles = 0;

	// predicted selector state
	logic [23:0]      map_reg;
	logic [7:0]       present_reg;
	logic [ST_W-1:0]  pt_state[NUM_PORTS];
	logic [ST_W-1:0]  ck_state[NUM_CLOCKS];
	logic [ST_W-1:0]  ck_pend[NUM_CLOCKS];
	logic [7:0]       tgt_flags;
	logic [CLK_W-1:0] ref_idx;
	logic             ref_on;
	logic             chg_flag;

	reference_clock_selector_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.port_number(port_number),
		.reported_state(reported_state),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.outcome(outcome),
		.reference_valid(reference_valid),
		.reference_clock(reference_clock),
		.target_mask(target_mask),
		.change_pending(change_pending)
	);

	always #1 clk = ~clk;

	function automatic int clock_of(int p);
		return int'(map_reg[3*p +: 3]);
	endfunction

	function automatic bit port_live(int p);
		if (p < 0 || p >= NUM_PORTS) return 1'b0;
		return present_reg[p] && clock_of(p) < NUM_CLOCKS;
	endfunction

	function automatic bit clock_live(int c);
		for (int p = 0; p < NUM_PORTS; p++)
			if (port_live(p) && clock_of(p) == c) return 1'b1;
		return 1'b0;
	endfunction

	// clock state is the largest state among its ports, never below disabled
	function automatic logic [ST_W-1:0] clock_max(int c);
		logic [ST_W-1:0] s;
		s = ST_DISABLED;
		for (int p = 0; p < NUM_PORTS; p++)
			if (port_live(p) && clock_of(p) == c && pt_state[p] > s) s = pt_state[p];
		return s;
	endfunction

	function automatic logic [2:0] pick_reference();
		int nref, ntgt, ref_c, last_c;
		bit have_ref;
		logic [ST_W-1:0] s;
		nref = 0;
		ntgt = 0;
		ref_c = 0;
		last_c = 0;
		have_ref = 1'b0;
		chg_flag = 1'b0;
		for (int c = 0; c < NUM_CLOCKS; c++) begin
			if (!clock_live(c)) continue;
			if (ck_pend[c] != ST_NONE) begin
				ck_state[c] = ck_pend[c];
				ck_pend[c] = ST_NONE;
			end
			s = ck_state[c];
			if (s >= ST_FAULTY && s <= ST_PASSIVE) begin
				tgt_flags[c] = 1'b1;
				ntgt++;
			end else if (s == ST_UNCAL) begin
				nref++;
			end else if (s == ST_SLAVE) begin
				ref_c = c;
				have_ref = 1'b1;
				nref++;
			end
			last_c = c;
		end
		// fall back to the highest existing clock when targets exist but no clock is slave
		if (ntgt >= 1 && !have_ref) begin
			ref_idx = CLK_W'(last_c);
			ref_on = 1'b1;
			tgt_flags[last_c] = 1'b0;
			ck_pend[last_c] = ck_state[last_c];
			ck_state[last_c] = ST_SLAVE;
			return OUT_DEFAULT_REF;
		end
		ref_on = 1'b0;
		ref_idx = '0;
		if (nref > 1) return OUT_MULTIPLE_REFS;
		if (nref > 0 && !have_ref) return OUT_REF_NOT_READY;
		if (nref == 0 && ntgt == 0) return OUT_NONE_READY;
		if (nref == 0) return OUT_NOTHING_SYNC;
		tgt_flags[ref_c] = 1'b0;
		ref_idx = CLK_W'(ref_c);
		ref_on = 1'b1;
		return OUT_REF_SELECTED;
	endfunction

	function automatic sel_result_t predict_step(sel_cmd_t it);
		sel_result_t r;
		int p, c;
		logic [ST_W-1:0] s;
		r.outcome = OUT_NO_ACTION;
		case (it.cmd)
			CMD_PORT_UPD: begin
				if (it.pnum == 0 || !port_live(int'(it.pnum) - 1)) begin
					r.outcome = OUT_UNKNOWN_PORT;
				end else begin
					p = int'(it.pnum) - 1;
					if (pt_state[p] != it.pst) begin
						pt_state[p] = it.pst;
						c = clock_of(p);
						s = clock_max(c);
						if (ck_state[c] != s || ck_pend[c] != ST_NONE) begin
							ck_pend[c] = s;
							chg_flag = 1'b1;
						end
					end
				end
			end
			CMD_RECONFIG: begin
				if (chg_flag) r.outcome = pick_reference();
			end
			CMD_INIT: begin
				for (c = 0; c < NUM_CLOCKS; c++)
					if (clock_live(c)) ck_pend[c] = clock_max(c);
				chg_flag = 1'b1;
			end
			default: begin
			end
		endcase
		r.ref_valid = ref_on;
		r.ref_clk = ref_on ? ref_idx : '0;
		r.tmask = tgt_flags;
		r.pend = chg_flag;
		return r;
	endfunction

	task automatic flag_error(string msg);
		if (err_count < 100) $display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic queue_cmd(logic [1:0] cmd, logic [3:0] pnum, logic [ST_W-1:0] pst);
		command_q.push_back('{cmd, pnum, pst});
		cmds_queued++;
	endtask

	// mostly port updates, largely in range with states 1 to 9; also reconfigure, init and unused
	task automatic queue_random_cmd();
		int r;
		r = $urandom_range(99);
		if (r < 60) begin
			queue_cmd(CMD_PORT_UPD,
				(r < 56) ? 4'($urandom_range(NUM_PORTS, 1)) : 4'($urandom_range(15)),
				($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9, 1)));
		end else if (r < 85) begin
			queue_cmd(CMD_RECONFIG, 4'($urandom_range(15)), 4'($urandom_range(15)));
		end else if (r < 93) begin
			queue_cmd(CMD_INIT, 4'($urandom_range(15)), 4'($urandom_range(15)));
		end else begin
			queue_cmd(CMD_UNUSED, 4'($urandom_range(15)), 4'($urandom_range(15)));
		end
	endtask

	// wait until every queued item is transferred and its result checked
	task automatic drain();
		while (!(in_xfers == cmds_queued && selection_q.size() == 0)) @(negedge clk);
	endtask

	task automatic set_regs(logic [23:0] map, logic [7:0] present);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_PORT_CLOCK_MAP;
		cfg_data <= map;
		@(negedge clk);
		cfg_index <= REG_PORT_PRESENT_MASK;
		cfg_data <= {16'd0, present};
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// driver: new item only once the previous one has transferred
	always @(negedge clk) begin
		sel_cmd_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && in_xfers != cmds_offered) begin
			// hold payload until transfer
		end else if (command_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			nxt = command_q.pop_front();
			in_valid <= 1'b1;
			command <= nxt.cmd;
			port_number <= nxt.pnum;
			reported_state <= nxt.pst;
			cmds_offered++;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result side backpressure, with one long hold-off on request
	always @(negedge clk) begin
		if (stall_long && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: track register writes, check results, predict accepted items
	always @(posedge clk) begin
		sel_result_t got, want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_PORT_CLOCK_MAP) map_reg = cfg_data;
				else present_reg = cfg_data[7:0];
			end
			if (out_valid && out_ready) begin
				got = '{outcome, reference_valid, reference_clock, target_mask, change_pending};
				if (selection_q.size() == 0) begin
					flag_error($sformatf("unexpected result %0h", got));
				end else begin
					want = selection_q.pop_front();
					check_field("outcome", 8'(got.outcome), 8'(want.outcome));
					check_field("reference_valid", 8'(got.ref_valid), 8'(want.ref_valid));
					check_field("reference_clock", 8'(got.ref_clk), 8'(want.ref_clk));
					check_field("target_mask", got.tmask, want.tmask);
					check_field("change_pending", 8'(got.pend), 8'(want.pend));
				end
			end
			if (in_valid && in_ready) begin
				selection_q.push_back(predict_step('{command, port_number, reported_state}));
				in_xfers <= in_xfers + 1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("ERROR: no transfer for %0d cycles", QUIET_MAX);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int n;
		logic [23:0] map;
		logic [7:0] present;
		map_reg = '0;
		present_reg = '0;
		for (int i = 0; i < NUM_PORTS; i++) pt_state[i] = ST_DISABLED;
		for (int i = 0; i < NUM_CLOCKS; i++) begin
			ck_state[i] = ST_NONE;
			ck_pend[i] = ST_NONE;
		end
		tgt_flags = '0;
		ref_idx = '0;
		ref_on = 1'b0;
		chg_flag = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// no port exists yet
		queue_cmd(CMD_PORT_UPD, 4'd1, ST_SLAVE);
		queue_cmd(CMD_RECONFIG, 4'd0, 4'd0);
		drain();

		// one port per clock
		set_regs(24'o76543210, 8'hFF);
		queue_cmd(CMD_UNUSED, 4'd15, 4'd15);
		queue_cmd(CMD_RECONFIG, 4'd0, 4'd0);
		queue_cmd(CMD_INIT, 4'd0, 4'd0);
		queue_cmd(CMD_RECONFIG, 4'd0, 4'd0);
		queue_cmd(CMD_PORT_UPD, 4'd1, ST_SLAVE);
		queue_cmd(CMD_RECONFIG, 4'd0, 4'd0);
		queue_cmd(CMD_PORT_UPD, 4'd1, ST_SLAVE);
		queue_cmd(CMD_PORT_UPD, 4'd0, 4'd4);
		queue_cmd(CMD_PORT_UPD, 4'd15, 4'd15);
		queue_cmd(CMD_PORT_UPD, 4'd2, ST_UNCAL);
		queue_cmd(CMD_PORT_UPD, 4'd3, 4'd0);
		queue_cmd(CMD_PORT_UPD, 4'd4, 4'd15);
		queue_cmd(CMD_PORT_UPD, 4'd5, 4'd1);
		queue_cmd(CMD_PORT_UPD, 4'd6, ST_FAULTY);
		queue_cmd(CMD_PORT_UPD, 4'd8, 4'd4);
		queue_cmd(CMD_RECONFIG, 4'd0, 4'd0);
		queue_cmd(CMD_INIT, 4'd0, 4'd0);
		queue_cmd(CMD_RECONFIG, 4'd0, 4'd0);
		drain();

		// lone clock: odd state gives none ready, uncalibrated gives not ready
		set_regs(24'd0, 8'h01);
		queue_cmd(CMD_PORT_UPD, 4'd1, 4'd12);
		queue_cmd(CMD_RECONFIG, 4'd0, 4'd0);
		queue_cmd(CMD_PORT_UPD, 4'd1, ST_UNCAL);
		queue_cmd(CMD_RECONFIG, 4'd0, 4'd0);
		drain();

		// uncalibrated and slave clocks side by side
		set_regs(24'o76543210, 8'h03);
		queue_cmd(CMD_PORT_UPD, 4'd2, ST_SLAVE);
		queue_cmd(CMD_RECONFIG, 4'd0, 4'd0);

		for (int k = 0; k < 10; k++) begin
			drain();
			case (k)
				0: begin
					map = 24'd0;
					present = 8'hFF;
				end
				1: begin
					map = 24'hFFFFFF;
					present = 8'hFF;
				end
				2: begin
					map = 24'hFFFFFF;
					present = 8'h00;
				end
				default: begin
					if ($urandom_range(1) == 0) begin
						for (int p = 0; p < NUM_PORTS; p++) map[3*p +: 3] = 3'($urandom_range(2));
					end else begin
						map = 24'($urandom);
					end
					present = 8'($urandom_range(255)) | (8'd1 << $urandom_range(7));
				end
			endcase
			set_regs(map, present);
			case (k / 2)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 83;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 83;
				end
				3: begin
					send_idle_pct = 35;
					recv_stall_pct = 35;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					stall_long = 1'b1;
				end
			endcase
			n = (k == 2) ? 15 : 55;
			repeat (n) queue_random_cmd();
		end

		drain();
		repeat (TAIL_WAIT) @(posedge clk);
		if (selection_q.size() != 0)
			flag_error($sformatf("%0d results never arrived", selection_q.size()));
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
